// File: sv/ssp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_pkg: shared types, constants and helpers of the size string parser
// Holds the character codes, the parse phase and status encodings and the
// byte classification and suffix decode functions.
// ----------------------------------------------------------------------------
package ssp_pkg;

   // Width of the accumulated value (16 to 64) and of the result port.
   localparam int VALUE_WIDTH = 64;
   localparam int SIZE_WIDTH  = 64;
   localparam int SHIFT_WIDTH = 6;    // holds 10 * 6 = 60

   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {VALUE_WIDTH{1'b1}};

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5a;
   localparam logic [7:0] CH_CASE  = 8'h20;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_K     = 8'h6b;
   localparam logic [7:0] CH_M     = 8'h6d;
   localparam logic [7:0] CH_G     = 8'h67;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_P     = 8'h70;
   localparam logic [7:0] CH_E     = 8'h65;

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_SIGN,
      PH_DIGITS,
      PH_TRAIL
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_NEGATIVE,
      ST_NO_DIGITS,
      ST_SUFFIX_MISPLACED,
      ST_TOO_LARGE,
      ST_UNKNOWN_SUFFIX
   } status_type;

   // Parse state seen by the result logic.
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] acc;
      logic                   overflow_seen;
      logic                   minus_seen;
      logic                   digit_seen;
      logic [7:0]             suffix_char;
      logic [1:0]             trailing_count;
   } scan_state_type;

   typedef struct packed {
      logic                   known;
      logic [SHIFT_WIDTH-1:0] shift;
   } suffix_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // Decode a suffix letter into its left shift (10 bits per step of 1024).
   function automatic suffix_type suffix_decode(input logic [7:0] c);
      logic [7:0] lc;
      suffix_type s;
      lc = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? (c | CH_CASE) : c;
      s.known = 1'b1;
      case (lc)
         CH_B:    s.shift = SHIFT_WIDTH'(0);
         CH_K:    s.shift = SHIFT_WIDTH'(10);
         CH_M:    s.shift = SHIFT_WIDTH'(20);
         CH_G:    s.shift = SHIFT_WIDTH'(30);
         CH_T:    s.shift = SHIFT_WIDTH'(40);
         CH_P:    s.shift = SHIFT_WIDTH'(50);
         CH_E:    s.shift = SHIFT_WIDTH'(60);
         default: begin
            s.known = 1'b0;
            s.shift = SHIFT_WIDTH'(0);
         end
      endcase
      return s;
   endfunction

endpackage

// File: sv/size_string_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_string_parser: ASCII decimal size string to binary value
// Top level: input byte register, parse state, result register.
// ----------------------------------------------------------------------------
// Feed a size string one byte per transaction, ending with a NUL byte. Leading
// whitespace (space, tab through carriage return) is skipped, one plus sign is
// allowed, decimal digits are accumulated with saturation, and at most one
// suffix letter may follow (b, k, m, g, t, p, e in either case, each step a
// factor of 1024). Only the NUL byte produces a response transaction: the
// scaled value and a status (0 ok, 1 negative, 2 no digits, 3 suffix
// misplaced, 4 too large, 5 unknown suffix); the value is 0 unless the status
// is ok. The parser then clears itself for the next string. Each byte is held in
// the input register and consumed by the parse logic from there, so a new byte
// is accepted every cycle, except while a held NUL waits because the result
// register still holds an untaken response.
// ----------------------------------------------------------------------------
module size_string_parser import ssp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_char_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SIZE_WIDTH-1:0] rsp_size_value,
   output logic [2:0]            rsp_status
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff, in_byte_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SIZE_WIDTH-1:0]  rsp_value_ff, rsp_value_in;
   status_type             rsp_status_ff, rsp_status_in;

   logic                   is_nul;
   logic                   out_free;
   logic                   take;
   scan_state_type         state;
   logic [VALUE_WIDTH-1:0] fin_value;
   status_type             fin_status;

   // Consume the held byte unless it is a NUL with the result slot still full.
   assign is_nul    = (in_byte_ff == CH_NUL);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign take      = in_valid_ff && (!is_nul || out_free);
   assign req_ready = !in_valid_ff || take;

   ssp_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .char_byte (in_byte_ff),
      .state     (state)
   );

   ssp_finish u_finish (
      .state  (state),
      .value  (fin_value),
      .status (fin_status)
   );

   // Input register: load on accept, drop once consumed.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_char_byte;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register: load at the terminator, hold until taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (take && is_nul) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = SIZE_WIDTH'(fin_value);
         rsp_status_in = fin_status;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_size_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// File: sv/ssp_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_scan: per-byte parse state
// Tracks the parse phase, accumulates decimal digits with saturation and
// records the sign and trailing bytes. Clears itself when the NUL is taken.
// ----------------------------------------------------------------------------
module ssp_scan import ssp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           take,        // a byte is consumed this cycle
   input  logic [7:0]     char_byte,
   output scan_state_type state
);

   phase_type      phase_ff, phase_in;
   scan_state_type st_ff, st_in;

   logic                   digit;
   logic                   space;
   logic                   add_digit;
   logic [VALUE_WIDTH+3:0] acc_ext;
   logic [VALUE_WIDTH+3:0] acc_next;
   logic                   acc_over;

   assign digit = is_digit(char_byte);
   assign space = is_space(char_byte);

   // acc * 10 + d; it overflows exactly when the top four bits are nonzero.
   assign acc_ext  = (VALUE_WIDTH+4)'(st_ff.acc);
   assign acc_next = (acc_ext << 3) + (acc_ext << 1) + (VALUE_WIDTH+4)'(char_byte[3:0]);
   assign acc_over = |acc_next[VALUE_WIDTH+3:VALUE_WIDTH];

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         if (char_byte == CH_NUL) begin
            phase_in = PH_SPACE;
         end else begin
            unique case (phase_ff)
               PH_SPACE: begin
                  if (space) begin
                     phase_in = PH_SPACE;
                  end else if ((char_byte == CH_PLUS) || (char_byte == CH_MINUS)) begin
                     phase_in = PH_SIGN;
                  end else if (digit) begin
                     phase_in = PH_DIGITS;
                  end else begin
                     phase_in = PH_TRAIL;
                  end
               end
               PH_SIGN:   phase_in = digit ? PH_DIGITS : PH_TRAIL;
               PH_DIGITS: phase_in = digit ? PH_DIGITS : PH_TRAIL;
               PH_TRAIL:  phase_in = PH_TRAIL;
               default:   phase_in = PH_SPACE;
            endcase
         end
      end
   end

   assign add_digit = digit && ((phase_ff == PH_SPACE) || (phase_ff == PH_SIGN) ||
                                (phase_ff == PH_DIGITS));

   // Datapath of the parse state.
   always_comb begin
      st_in = st_ff;
      if (take) begin
         if (char_byte == CH_NUL) begin
            st_in = '0;
         end else begin
            if (char_byte == CH_MINUS) begin
               st_in.minus_seen = 1'b1;
            end
            if (add_digit) begin
               st_in.digit_seen = 1'b1;
               if (!st_ff.overflow_seen) begin
                  if (acc_over) begin
                     st_in.acc           = VALUE_MAX;
                     st_in.overflow_seen = 1'b1;
                  end else begin
                     st_in.acc = acc_next[VALUE_WIDTH-1:0];
                  end
               end
            end else if ((phase_ff == PH_DIGITS) && !digit) begin
               st_in.suffix_char    = char_byte;
               st_in.trailing_count = 2'd1;
            end else if ((phase_ff == PH_TRAIL) && (st_ff.trailing_count != 2'd2)) begin
               st_in.trailing_count = st_ff.trailing_count + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SPACE;
         st_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         st_ff    <= st_in;
      end
   end

   assign state = st_ff;

endmodule

// File: sv/ssp_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_finish: result evaluation at the terminator
// Runs the status checks in priority order and scales the value by the
// suffix, flagging a scaled value that no longer fits.
// ----------------------------------------------------------------------------
module ssp_finish import ssp_pkg::*; (
   input  scan_state_type         state,
   output logic [VALUE_WIDTH-1:0] value,
   output status_type             status
);

   suffix_type             sfx;
   logic [SHIFT_WIDTH-1:0] shift;
   logic [VALUE_WIDTH-1:0] hi_mask;
   logic                   scale_over;

   assign sfx   = suffix_decode(state.suffix_char);
   assign shift = (state.trailing_count == 2'd1) ? sfx.shift : SHIFT_WIDTH'(0);

   // Bits that would be pushed out by the shift; any set one is too large.
   assign hi_mask    = ~(VALUE_MAX >> shift);
   assign scale_over = |(state.acc & hi_mask);

   always_comb begin
      value  = '0;
      status = ST_OK;
      if (state.minus_seen) begin
         status = ST_NEGATIVE;
      end else if (!state.digit_seen) begin
         status = ST_NO_DIGITS;
      end else if (state.trailing_count[1]) begin
         status = ST_SUFFIX_MISPLACED;
      end else if (state.overflow_seen) begin
         status = ST_TOO_LARGE;
      end else if ((state.trailing_count == 2'd1) && !sfx.known) begin
         status = ST_UNKNOWN_SUFFIX;
      end else if (scale_over) begin
         status = ST_TOO_LARGE;
      end else begin
         value = state.acc << shift;
      end
   end

endmodule
